@@ hw/rtl/bmh_pkg.sv @@
// Package for the binary max heap queue: sizes, key type, status codes and
// controller states. No dependencies.
package bmh_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W   = ADDR_W + 2;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CHILD_W-1:0]   child_t;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_PUT,
        S_DN_LOAD,
        S_DN_CMP,
        S_REPLY
    } state_t;

endpackage

@@ hw/rtl/bmh_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module bmh_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

@@ hw/rtl/binary_max_heap_queue.sv @@
// Top level of the binary max heap queue: command port, sift controller and heap store.
// Depends on bmh_pkg and bmh_ram.
//
//   channel   handshake            payload
//   command   start / busy         action, key_in
//   result    done (one cycle)     status, top_key, top_valid, entry_count
//
// An insert rises one level per compare and puts the key at the root if it gets there; a
// remove loads the last key into the root and sinks one level per compare. One sift level
// per cycle is set by the heap store's registered read port feeding the compare.
// Reset clears the count and the controller; the store is not cleared.
// done is high for one cycle and is not held off; busy drops the cycle after.
module binary_max_heap_queue
    import bmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] key_in,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] top_key,
    output logic        top_valid,
    output logic [10:0] entry_count
);

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    addr_t   pos_reg, pos_next;
    key_t    key_reg, key_next;
    key_t    root_reg, root_next;
    status_t status_reg, status_next;

    logic    mem_we;
    addr_t   mem_waddr;
    key_t    mem_wdata;
    addr_t   ra_addr;
    addr_t   rb_addr;
    key_t    ra_data;
    key_t    rb_data;

    logic    accept;
    addr_t   parent_pos;
    logic    up_swap;
    child_t  left_idx;
    child_t  right_idx;
    logic    left_big;
    key_t    left_best;
    logic    right_big;
    logic    dn_swap;
    addr_t   big_pos;
    key_t    big_key;
    child_t  next_left;

    assign accept = start && (state_reg == S_IDLE);

    assign parent_pos = (pos_reg - addr_t'(1)) >> 1;
    assign up_swap    = key_reg > ra_data;

    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + child_t'(1);
    assign left_big  = (left_idx < child_t'(count_reg)) && (ra_data > key_reg);
    assign left_best = left_big ? ra_data : key_reg;
    assign right_big = (right_idx < child_t'(count_reg)) && (rb_data > left_best);
    assign dn_swap   = left_big || right_big;
    assign big_pos   = right_big ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    assign big_key   = right_big ? rb_data : ra_data;
    assign next_left = {1'b0, big_pos, 1'b1};

    bmh_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (ra_addr),
        .ra_data (ra_data),
        .rb_addr (rb_addr),
        .rb_data (rb_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_INSERT)
                    begin
                        if (count_reg == count_t'(CAPACITY) || count_reg == '0)
                            state_next = S_REPLY;
                        else
                            state_next = S_UP_CMP;
                    end
                    else
                    begin
                        if (count_reg == '0 || count_reg == count_t'(1))
                            state_next = S_REPLY;
                        else
                            state_next = S_DN_LOAD;
                    end
                end
            end
            S_UP_CMP:
            begin
                if (!up_swap)
                    state_next = S_REPLY;
                else if (parent_pos == '0)
                    state_next = S_PUT;
            end
            S_PUT:     state_next = S_REPLY;
            S_DN_LOAD: state_next = S_DN_CMP;
            S_DN_CMP:
            begin
                if (!dn_swap)
                    state_next = S_REPLY;
            end
            S_REPLY:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        root_next   = root_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = key_reg;
        ra_addr     = parent_pos;
        rb_addr     = parent_pos;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    key_next    = key_in;
                    pos_next    = count_reg[ADDR_W-1:0];
                    ra_addr     = (count_reg[ADDR_W-1:0] - addr_t'(1)) >> 1;
                    if (action == ACT_INSERT)
                    begin
                        if (count_reg == count_t'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + count_t'(1);
                            if (count_reg == '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = key_in;
                                root_next = key_in;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - count_t'(1);
                            ra_addr    = count_next[ADDR_W-1:0];
                        end
                    end
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (up_swap)
                begin
                    mem_wdata = ra_data;
                    pos_next  = parent_pos;
                    ra_addr   = (parent_pos - addr_t'(1)) >> 1;
                end
                else if (pos_reg == '0)
                begin
                    root_next = key_reg;
                end
            end
            S_PUT:
            begin
                mem_we = 1'b1;
                if (pos_reg == '0)
                    root_next = key_reg;
            end
            S_DN_LOAD:
            begin
                key_next = ra_data;
                pos_next = '0;
                ra_addr  = addr_t'(1);
                rb_addr  = addr_t'(2);
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (dn_swap)
                begin
                    mem_wdata = big_key;
                    pos_next  = big_pos;
                    ra_addr   = next_left[ADDR_W-1:0];
                    rb_addr   = next_left[ADDR_W-1:0] + addr_t'(1);
                    if (pos_reg == '0)
                        root_next = big_key;
                end
                else if (pos_reg == '0)
                begin
                    root_next = key_reg;
                end
            end
            S_REPLY:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        root_reg   <= root_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_REPLY);
    assign status      = status_reg;
    assign top_valid   = (count_reg != '0);
    assign top_key     = top_valid ? root_reg : '0;
    assign entry_count = count_reg;

endmodule

@@ tb/binary_max_heap_queue_tb.sv @@
`timescale 1ns / 1ps
// Testbench for binary_max_heap_queue: sends insert and remove transactions and checks each
// result against a behavioral max heap held here. Depends on bmh_pkg and the heap queue RTL.
module binary_max_heap_queue_tb;
    import bmh_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        status_t status;
        key_t    top_key;
        logic    top_valid;
        count_t  entry_count;
    } heap_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = ACT_INSERT;
    logic [31:0] key_in = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] top_key;
    logic        top_valid;
    logic [10:0] entry_count;

    key_t         heap_keys [CAPACITY];
    int           heap_size = 0;
    heap_result_t pending_results [$];

    int mismatch_count = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int insert_count = 0;
    int remove_count = 0;
    int full_drops = 0;
    int empty_removes = 0;
    int peak_size = 0;

    binary_max_heap_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key_in      (key_in),
        .done        (done),
        .status      (status),
        .top_key     (top_key),
        .top_valid   (top_valid),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void heap_sift_up(int pos);
        int   parent;
        key_t held;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (!(heap_keys[pos] > heap_keys[parent]))
                break;
            held = heap_keys[pos];
            heap_keys[pos] = heap_keys[parent];
            heap_keys[parent] = held;
            pos = parent;
        end
    endfunction

    function automatic void heap_sift_down();
        int   pos;
        int   left_child;
        int   right_child;
        int   larger;
        key_t held;
        pos = 0;
        while (1)
        begin
            left_child = 2 * pos + 1;
            right_child = left_child + 1;
            larger = pos;
            if (left_child < heap_size && heap_keys[left_child] > heap_keys[larger])
                larger = left_child;
            if (right_child < heap_size && heap_keys[right_child] > heap_keys[larger])
                larger = right_child;
            if (larger == pos)
                break;
            held = heap_keys[pos];
            heap_keys[pos] = heap_keys[larger];
            heap_keys[larger] = held;
            pos = larger;
        end
    endfunction

    function automatic heap_result_t apply_heap_op(logic op, key_t key);
        heap_result_t outcome;
        outcome.status = ST_OK;
        if (op == ACT_INSERT)
        begin
            insert_count++;
            if (heap_size >= CAPACITY)
            begin
                outcome.status = ST_FULL;
                full_drops++;
            end
            else
            begin
                heap_keys[heap_size] = key;
                heap_size++;
                heap_sift_up(heap_size - 1);
            end
        end
        else
        begin
            remove_count++;
            if (heap_size == 0)
            begin
                outcome.status = ST_EMPTY;
                empty_removes++;
            end
            else
            begin
                heap_size--;
                heap_keys[0] = heap_keys[heap_size];
                heap_sift_down();
            end
        end
        if (heap_size > peak_size)
            peak_size = heap_size;
        outcome.top_valid = (heap_size > 0);
        outcome.top_key = (heap_size > 0) ? heap_keys[0] : '0;
        outcome.entry_count = count_t'(heap_size);
        return outcome;
    endfunction

    function automatic key_t pick_key();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0, 1: return key_t'($urandom_range(0, 7));
            2:    return $urandom_range(0, 1) ? '1 : '0;
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic send_transaction(input logic op, input key_t key);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(5, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= op;
        key_in <= key;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_heap_op(op, key));
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0h, actual %0h", what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        heap_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result with no transaction pending", '0, top_key);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(status));
                if (top_key !== want.top_key)
                    flag_mismatch("top_key", want.top_key, top_key);
                if (top_valid !== want.top_valid)
                    flag_mismatch("top_valid", 32'(want.top_valid), 32'(top_valid));
                if (entry_count !== want.entry_count)
                    flag_mismatch("entry_count", 32'(want.entry_count), 32'(entry_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed_edges();
        send_transaction(ACT_REMOVE, '0);
        send_transaction(ACT_REMOVE, '1);
        send_transaction(ACT_INSERT, 32'h0000_0000);
        send_transaction(ACT_INSERT, 32'h0000_0000);
        send_transaction(ACT_INSERT, 32'hFFFF_FFFF);
        send_transaction(ACT_INSERT, 32'hFFFF_FFFF);
        send_transaction(ACT_INSERT, 32'h8000_0000);
        send_transaction(ACT_INSERT, 32'h7FFF_FFFF);
        send_transaction(ACT_INSERT, 32'h0000_0001);
        send_transaction(ACT_INSERT, 32'hFFFF_FFFE);
        send_transaction(ACT_INSERT, 32'hAAAA_AAAA);
        send_transaction(ACT_INSERT, 32'h5555_5555);
        repeat (11) send_transaction(ACT_REMOVE, 32'h1234_5678);
        send_transaction(ACT_REMOVE, '0);
    endtask

    task automatic test_random_churn(input int item_total);
        int insert_pct;
        repeat (item_total)
        begin
            if (heap_size < 8)
                insert_pct = 70;
            else if (heap_size > 200)
                insert_pct = 30;
            else
                insert_pct = 50;
            if ($urandom_range(0, 99) < insert_pct)
                send_transaction(ACT_INSERT, pick_key());
            else
                send_transaction(ACT_REMOVE, key_t'($urandom));
        end
    endtask

    task automatic test_fill_to_capacity();
        while (heap_size < CAPACITY)
        begin
            if ($urandom_range(0, 19) != 0)
                send_transaction(ACT_INSERT, pick_key());
            else
                send_transaction(ACT_REMOVE, key_t'($urandom));
        end
        send_transaction(ACT_INSERT, '1);
        send_transaction(ACT_INSERT, pick_key());
        send_transaction(ACT_REMOVE, '0);
        send_transaction(ACT_INSERT, pick_key());
        send_transaction(ACT_INSERT, '0);
    endtask

    task automatic test_drain_partial(input int item_total);
        repeat (item_total)
        begin
            if ($urandom_range(0, 9) != 0)
                send_transaction(ACT_REMOVE, key_t'($urandom));
            else
                send_transaction(ACT_INSERT, pick_key());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_random_churn(200);
        test_fill_to_capacity();
        test_drain_partial(200);
        test_random_churn(50);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d transactions: %0d inserts (%0d full), %0d removes (%0d empty)",
                 insert_count + remove_count, insert_count, full_drops, remove_count,
                 empty_removes);
        $display("peak occupancy %0d of %0d keys, %0d results checked, %0d mismatches",
                 peak_size, CAPACITY, results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ binary_max_heap_queue.f @@
hw/rtl/bmh_pkg.sv
hw/rtl/bmh_ram.sv
hw/rtl/binary_max_heap_queue.sv
tb/binary_max_heap_queue_tb.sv
